// ===== src/sdte_pkg.sv =====
package sdte_pkg;

    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    localparam logic [1:0] KIND_BODY     = 2'd0;
    localparam logic [1:0] KIND_SURPLUS  = 2'd1;
    localparam logic [1:0] KIND_STD_END  = 2'd2;
    localparam logic [1:0] KIND_BARE_END = 2'd3;

    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_DOT  = 2'd1;
    localparam logic [1:0] HOLD_CR   = 2'd2;

    localparam logic REG_SEND  = 1'b0;
    localparam logic REG_ALLOW = 1'b1;

    localparam int MAX_RES = 3;

    typedef struct packed {
        logic send;
        logic allow;
    } t_cfg;

    typedef struct packed {
        logic [15:0] prev;
        logic [1:0]  hold;
        logic        bare;
        logic        ended;
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } t_res;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
        logic       new_transfer;
    } t_item;

endpackage

// ===== src/sdte_if.sv =====
interface sdte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_end;
    logic       new_transfer;

    modport source(output valid, data_byte, chunk_end, new_transfer, input ready);
    modport sink(input valid, data_byte, chunk_end, new_transfer, output ready);
endinterface

interface sdte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source(output valid, out_byte, kind, last, input ready);
    modport sink(input valid, out_byte, kind, last, output ready);
endinterface

// ===== src/sdte_cfg.sv =====
module sdte_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output sdte_pkg::t_cfg o_cfg
);
    import sdte_pkg::*;

    t_cfg r_cfg;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            case (paddr[2])
                REG_SEND:  r_cfg.send  <= pwdata[0];
                REG_ALLOW: r_cfg.allow <= pwdata[0];
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_SEND:  prdata[0] = r_cfg.send;
            REG_ALLOW: prdata[0] = r_cfg.allow;
            default:   prdata    = '0;
        endcase
    end
endmodule

// ===== src/sdte_step.sv =====
module sdte_step (
    input  sdte_pkg::t_item  i_item,
    input  sdte_pkg::t_state i_state,
    input  sdte_pkg::t_cfg   i_cfg,
    output sdte_pkg::t_state o_state,
    output sdte_pkg::t_res   o_res [sdte_pkg::MAX_RES],
    output logic [1:0]       o_cnt
);
    import sdte_pkg::*;

    t_state     cur;
    logic [7:0] b;
    logic [7:0] p1;
    logic [7:0] p2;
    logic       ce;
    logic       plain;

    always_comb begin
        b  = i_item.data_byte;
        ce = i_item.chunk_end;
        if (i_item.new_transfer) begin
            cur = '{prev: {CH_CR, CH_LF}, hold: HOLD_NONE, bare: 1'b0, ended: 1'b0};
        end else begin
            cur = i_state;
        end
        p1 = cur.prev[7:0];
        p2 = cur.prev[15:8];

        o_state      = cur;
        o_state.prev = {p1, b};
        o_cnt        = '0;
        plain        = 1'b0;
        for (int k = 0; k < MAX_RES; k++) begin
            o_res[k] = '0;
        end

        if (cur.ended) begin
            o_res[o_cnt] = '{data: b, kind: KIND_SURPLUS};
            o_cnt = o_cnt + 2'd1;
        end else if (i_cfg.send) begin
            // pass on a CR left over from receive mode, then stuff
            if (cur.hold == HOLD_CR) begin
                o_res[o_cnt] = '{data: CH_CR, kind: KIND_BODY};
                o_cnt = o_cnt + 2'd1;
            end
            o_state.hold = HOLD_NONE;
            if (b == CH_DOT && p1 == CH_LF) begin
                o_res[o_cnt] = '{data: CH_DOT, kind: KIND_BODY};
                o_cnt = o_cnt + 2'd1;
            end
            o_res[o_cnt] = '{data: b, kind: KIND_BODY};
            o_cnt = o_cnt + 2'd1;
        end else if (cur.hold == HOLD_CR) begin
            o_state.hold = HOLD_NONE;
            if (b == CH_LF && !cur.bare) begin
                o_res[o_cnt] = '{data: 8'h00, kind: KIND_STD_END};
                o_cnt = o_cnt + 2'd1;
                o_state.ended = 1'b1;
            end else if (b == CH_LF && i_cfg.allow && ce) begin
                o_res[o_cnt] = '{data: 8'h00, kind: KIND_BARE_END};
                o_cnt = o_cnt + 2'd1;
                o_state.ended = 1'b1;
            end else begin
                // not a marker: release the held CR
                o_res[o_cnt] = '{data: CH_CR, kind: KIND_BODY};
                o_cnt = o_cnt + 2'd1;
                o_res[o_cnt] = '{data: b, kind: KIND_BODY};
                o_cnt = o_cnt + 2'd1;
            end
        end else if (cur.hold == HOLD_DOT) begin
            o_state.hold = HOLD_NONE;
            if (b == CH_CR) begin
                o_state.hold = HOLD_CR;
            end else if (b == CH_LF && i_cfg.allow && ce) begin
                o_res[o_cnt] = '{data: 8'h00, kind: KIND_BARE_END};
                o_cnt = o_cnt + 2'd1;
                o_state.ended = 1'b1;
            end else begin
                plain = 1'b1;
            end
        end else begin
            o_state.hold = HOLD_NONE;
            plain = 1'b1;
        end

        if (plain) begin
            if (b == CH_DOT && p1 == CH_LF) begin
                // drop the line-leading dot, remember how the line began
                o_state.hold = HOLD_DOT;
                o_state.bare = (p2 != CH_CR);
            end else begin
                if (b == CH_LF && i_cfg.allow && p1 != CH_CR) begin
                    o_res[o_cnt] = '{data: CH_CR, kind: KIND_BODY};
                    o_cnt = o_cnt + 2'd1;
                end
                o_res[o_cnt] = '{data: b, kind: KIND_BODY};
                o_cnt = o_cnt + 2'd1;
            end
        end
    end
endmodule

// ===== src/sdte_obuf.sv =====
module sdte_obuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  sdte_pkg::t_res i_res [sdte_pkg::MAX_RES],
    input  logic [1:0]     i_cnt,
    output logic           o_can_load,
    sdte_out_if.source     o_out
);
    import sdte_pkg::*;

    t_res       r_ent [MAX_RES];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       xfer;

    assign xfer           = o_out.valid & o_out.ready;
    assign o_can_load     = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out.ready);
    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.out_byte = r_ent[0].data;
    assign o_out.kind     = r_ent[0].kind;
    assign o_out.last     = (r_cnt == 2'd1);

    always_comb begin
        if (i_load) begin
            n_cnt = i_cnt;
        end else if (xfer) begin
            n_cnt = r_cnt - 2'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_res;
        end else if (xfer) begin
            // advance the queue by one
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_ent[k] <= r_ent[k + 1];
            end
        end
    end
endmodule

// ===== src/smtp_data_transparency_engine_core.sv =====
// A byte taken in is registered in the input stage, then its results go to the result
// queue that offers them. One byte per cycle is taken while the port is ready and each
// byte yields at most one result; a byte with two or three results holds the input until
// the single result queue, draining one result per cycle while the port is ready, passes
// on its last. Reset (synchronous, active low) clears both registers, the per-transfer
// state (last raw bytes CR LF, nothing held) and empties the input and result stages.
module smtp_data_transparency_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdte_in_if.sink     i_in,
    sdte_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sdte_pkg::*;

    t_cfg       cfg;
    t_item      r_item;
    logic       r_item_vld;
    t_state     r_state;
    t_state     n_state;
    t_res       res [MAX_RES];
    logic [1:0] res_cnt;
    logic       can_load;
    logic       proc;
    logic       in_xfer;

    sdte_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign proc       = r_item_vld & can_load;
    assign i_in.ready = ~r_item_vld | can_load;
    assign in_xfer    = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_state    <= '{prev: {CH_CR, CH_LF}, hold: HOLD_NONE, bare: 1'b0, ended: 1'b0};
        end else begin
            r_item_vld <= in_xfer | (r_item_vld & ~proc);
            if (proc) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= '{data_byte: i_in.data_byte, chunk_end: i_in.chunk_end,
                        new_transfer: i_in.new_transfer};
        end
    end

    sdte_step u_step (
        .i_item  (r_item),
        .i_state (r_state),
        .i_cfg   (cfg),
        .o_state (n_state),
        .o_res   (res),
        .o_cnt   (res_cnt)
    );

    sdte_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (proc),
        .i_res      (res),
        .i_cnt      (res_cnt),
        .o_can_load (can_load),
        .o_out      (o_out)
    );
endmodule

// ===== src/sdte_checker.sv =====
module sdte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [1:0] i_out_kind,
    input logic       i_out_last
);
    import sdte_pkg::*;

    // hold a stalled result
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_byte) && $stable(i_out_kind) && $stable(i_out_last))
        else $error("stalled result changed");

    a_end_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_STD_END || i_out_kind == KIND_BARE_END)
            |-> i_out_byte == 8'h00 && i_out_last)
        else $error("end event not a lone zero result");

    a_surplus_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_SURPLUS |-> i_out_last)
        else $error("surplus byte not the only result of its byte");

    // after a standard end event is taken, the result offered straight after it, if any, is surplus or body
    a_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_kind == KIND_STD_END
            |=> !i_out_valid || i_out_kind == KIND_SURPLUS || i_out_kind == KIND_BODY)
        else $error("second end event right after an end event");
endmodule

bind smtp_data_transparency_engine_core sdte_checker u_sdte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_kind  (o_out.kind),
    .i_out_last  (o_out.last)
);

// ===== tb/sdte_stream_compare.sv =====
module sdte_stream_compare (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdte_in_if          i_in_mon,
    sdte_out_if         i_out_mon,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_std_ends,
    output int          o_bare_ends,
    output int          o_surplus
);
    import sdte_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } stream_result_t;

    stream_result_t pending_out_bytes[$];
    t_cfg           cfg;
    t_state         xfer;
    int             mismatch_count;
    int             checked_count;
    int             std_end_count;
    int             bare_end_count;
    int             surplus_count;

    function automatic void queue_result(logic [7:0] b, logic [1:0] k);
        stream_result_t r;
        r.out_byte = b;
        r.kind     = k;
        r.last     = 1'b0;
        pending_out_bytes.push_back(r);
    endfunction

    function automatic void clear_transfer_state();
        xfer.prev  = {CH_CR, CH_LF};
        xfer.hold  = HOLD_NONE;
        xfer.bare  = 1'b0;
        xfer.ended = 1'b0;
    endfunction

    // Receive path with no marker wait pending.
    function automatic void unstuff_plain(logic [7:0] b, logic [7:0] p1, logic [7:0] p2);
        if (b == CH_DOT && p1 == CH_LF) begin
            xfer.hold = HOLD_DOT;
            xfer.bare = (p2 != CH_CR);
        end else begin
            if (b == CH_LF && cfg.allow && p1 != CH_CR) begin
                queue_result(CH_CR, KIND_BODY);
            end
            queue_result(b, KIND_BODY);
        end
    endfunction

    function automatic void apply_transparency(t_item it);
        logic [7:0]     b;
        logic [7:0]     p1;
        logic [7:0]     p2;
        int             n0;
        stream_result_t r;
        b = it.data_byte;
        if (it.new_transfer) begin
            clear_transfer_state();
        end
        p1 = xfer.prev[7:0];
        p2 = xfer.prev[15:8];
        n0 = pending_out_bytes.size();
        if (xfer.ended) begin
            queue_result(b, KIND_SURPLUS);
        end else if (cfg.send) begin
            if (xfer.hold == HOLD_CR) begin
                queue_result(CH_CR, KIND_BODY);
            end
            xfer.hold = HOLD_NONE;
            if (b == CH_DOT && p1 == CH_LF) begin
                queue_result(CH_DOT, KIND_BODY);
            end
            queue_result(b, KIND_BODY);
        end else if (xfer.hold == HOLD_CR) begin
            xfer.hold = HOLD_NONE;
            if (b == CH_LF && !xfer.bare) begin
                queue_result(8'h00, KIND_STD_END);
                xfer.ended = 1'b1;
            end else if (b == CH_LF && cfg.allow && it.chunk_end) begin
                queue_result(8'h00, KIND_BARE_END);
                xfer.ended = 1'b1;
            end else begin
                // not a marker: release the held CR ahead of this byte
                queue_result(CH_CR, KIND_BODY);
                queue_result(b, KIND_BODY);
            end
        end else if (xfer.hold == HOLD_DOT) begin
            xfer.hold = HOLD_NONE;
            if (b == CH_CR) begin
                xfer.hold = HOLD_CR;
            end else if (b == CH_LF && cfg.allow && it.chunk_end) begin
                queue_result(8'h00, KIND_BARE_END);
                xfer.ended = 1'b1;
            end else begin
                unstuff_plain(b, p1, p2);
            end
        end else begin
            xfer.hold = HOLD_NONE;
            unstuff_plain(b, p1, p2);
        end
        xfer.prev = {xfer.prev[7:0], b};
        if (pending_out_bytes.size() > n0) begin
            r = pending_out_bytes.pop_back();
            r.last = 1'b1;
            pending_out_bytes.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        stream_result_t exp_r;
        t_item          it;
        if (!i_rst_n) begin
            cfg.send  = 1'b0;
            cfg.allow = 1'b0;
            clear_transfer_state();
            pending_out_bytes.delete();
            mismatch_count = 0;
            checked_count  = 0;
            std_end_count  = 0;
            bare_end_count = 0;
            surplus_count  = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {REG_SEND, 2'b00}) begin
                    cfg.send = i_pwdata[0];
                end else if (i_paddr == {REG_ALLOW, 2'b00}) begin
                    cfg.allow = i_pwdata[0];
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (pending_out_bytes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("[%0t] unexpected result: byte %h kind %0d last %b", $realtime,
                                 i_out_mon.out_byte, i_out_mon.kind, i_out_mon.last);
                    end
                end else begin
                    exp_r = pending_out_bytes.pop_front();
                    checked_count++;
                    if (exp_r.kind == KIND_STD_END) std_end_count++;
                    if (exp_r.kind == KIND_BARE_END) bare_end_count++;
                    if (exp_r.kind == KIND_SURPLUS) surplus_count++;
                    if (i_out_mon.out_byte !== exp_r.out_byte || i_out_mon.kind !== exp_r.kind
                        || i_out_mon.last !== exp_r.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("[%0t] result mismatch: expected byte %h kind %0d last %b,",
                                     $realtime, exp_r.out_byte, exp_r.kind, exp_r.last,
                                     " got byte %h kind %0d last %b",
                                     i_out_mon.out_byte, i_out_mon.kind, i_out_mon.last);
                        end
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                it.data_byte    = i_in_mon.data_byte;
                it.chunk_end    = i_in_mon.chunk_end;
                it.new_transfer = i_in_mon.new_transfer;
                apply_transparency(it);
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= pending_out_bytes.size();
        o_checked    <= checked_count;
        o_std_ends   <= std_end_count;
        o_bare_ends  <= bare_end_count;
        o_surplus    <= surplus_count;
    end

endmodule

// ===== tb/smtp_data_transparency_engine_core_test.sv =====
module smtp_data_transparency_engine_core_test;
    import sdte_pkg::*;

    localparam int DIRECTED_ITEMS = 28;
    localparam int RANDOM_ITEMS   = 320;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int std_ends;
    int bare_ends;
    int surplus;

    int   burst_left = 0;
    int   items_sent = 0;
    int   settings_used = 0;
    logic next_nt = 1'b0;
    bit   long_stall_req = 1'b0;

    sdte_in_if  in_ch();
    sdte_out_if out_ch();

    smtp_data_transparency_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sdte_stream_compare compare_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_std_ends   (std_ends),
        .o_bare_ends  (bare_ends),
        .o_surplus    (surplus)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

    // Output side: stall on a pattern of randomly chosen modes, plus one long stall on request.
    initial begin : receiver
        int cyc;
        int mode;
        bit stall_done;
        cyc = 0;
        mode = 0;
        stall_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_stall_req && !stall_done) begin
                stall_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            if (cyc % 48 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                2: out_ch.ready <= ($urandom_range(0, 7) != 0);
                default: out_ch.ready <= ((cyc % 5) >= 2);
            endcase
            cyc++;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic ce, input logic nt);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= b;
        in_ch.chunk_end    <= ce;
        in_ch.new_transfer <= nt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // Message bytes: the first one of a message opens a new transfer.
    task automatic push_text(input logic [7:0] b, input logic ce);
        push_byte(b, ce, next_nt);
        next_nt = 1'b0;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // let a held dot or CR settle before touching the registers
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 7))
            0: return CH_DOT;
            1: return CH_CR;
            2: return CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic rnd_ce();
        return ($urandom_range(0, 7) == 0);
    endfunction

    // Stuffed lines, optional bare LF endings, an end marker, then some surplus.
    task automatic send_message();
        int n_lines;
        int len;
        next_nt = 1'b1;
        n_lines = $urandom_range(1, 4);
        repeat (n_lines) begin
            case ($urandom_range(0, 3))
                0: begin
                    push_text(CH_DOT, rnd_ce());
                    push_text(CH_DOT, rnd_ce());
                end
                1: begin
                    push_text(CH_DOT, rnd_ce());
                    push_text(8'($urandom_range(32, 126)), rnd_ce());
                end
                default: ;
            endcase
            len = $urandom_range(0, 6);
            repeat (len) push_text(text_byte(), rnd_ce());
            if ($urandom_range(0, 4) != 0) push_text(CH_CR, rnd_ce());
            push_text(CH_LF, rnd_ce());
        end
        push_text(CH_DOT, rnd_ce());
        case ($urandom_range(0, 3))
            0, 1: begin
                push_text(CH_CR, rnd_ce());
                push_text(CH_LF, rnd_ce());
            end
            2: push_text(CH_LF, 1'b1);
            default: begin
                push_text(CH_CR, rnd_ce());
                push_text(CH_LF, 1'b1);
            end
        endcase
        repeat ($urandom_range(0, 4)) push_text(text_byte(), rnd_ce());
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8)) begin
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 15) == 0));
        end
    endtask

    initial begin : stimulus
        logic send_sel;
        logic allow_sel;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= 8'h00;
        in_ch.chunk_end    <= 1'b0;
        in_ch.new_transfer <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 3'd0;
        pwdata  <= 32'd0;
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // receive, no bare LF: unstuffing, held CR release, dot-LF, standard end
        settings_used++;
        push_byte(CH_DOT, 1'b0, 1'b1);
        push_byte("a", 1'b0, 1'b0);
        push_byte(CH_LF, 1'b0, 1'b0);
        push_byte(CH_DOT, 1'b1, 1'b0);
        push_byte(CH_LF, 1'b0, 1'b0);
        push_byte(CH_DOT, 1'b0, 1'b0);
        push_byte(CH_CR, 1'b0, 1'b0);
        push_byte("x", 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(CH_CR, 1'b0, 1'b0);
        push_byte(CH_LF, 1'b0, 1'b0);
        push_byte(CH_DOT, 1'b0, 1'b0);
        push_byte(CH_CR, 1'b0, 1'b0);
        push_byte(CH_LF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);

        // bare LF allowed: repair, bare marker, new transfer drops a held CR
        wait_idle();
        write_reg(REG_SEND, 1'b0);
        write_reg(REG_ALLOW, 1'b1);
        settings_used++;
        push_byte("b", 1'b0, 1'b1);
        push_byte(CH_LF, 1'b0, 1'b0);
        push_byte(CH_DOT, 1'b0, 1'b0);
        push_byte(CH_LF, 1'b1, 1'b0);
        push_byte(CH_DOT, 1'b0, 1'b0);
        push_byte(CH_DOT, 1'b0, 1'b1);
        push_byte(CH_CR, 1'b0, 1'b0);
        push_byte("z", 1'b0, 1'b1);
        push_byte(CH_LF, 1'b0, 1'b0);
        push_byte(CH_DOT, 1'b0, 1'b0);
        push_byte(CH_CR, 1'b0, 1'b0);

        // switch to send with a CR still held, then stuff a leading dot
        wait_idle();
        write_reg(REG_SEND, 1'b1);
        settings_used++;
        push_byte(CH_DOT, 1'b0, 1'b0);
        push_byte(CH_LF, 1'b0, 1'b0);
        push_byte(CH_DOT, 1'b0, 1'b0);

        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            wait_idle();
            if (settings_used < 7) begin
                send_sel  = settings_used[1];
                allow_sel = settings_used[0];
            end else begin
                send_sel  = ($urandom_range(0, 3) == 0);
                allow_sel = 1'($urandom_range(0, 1));
            end
            write_reg(REG_SEND, send_sel);
            write_reg(REG_ALLOW, allow_sel);
            settings_used++;
            if (settings_used == 5) long_stall_req = 1'b1;
            repeat ($urandom_range(2, 4)) begin
                if ($urandom_range(0, 5) == 0) begin
                    send_noise();
                end else begin
                    send_message();
                end
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes under %0d register settings, checked %0d results.",
                 items_sent, settings_used, checked);
        $display("End markers: %0d standard, %0d bare LF; %0d surplus bytes passed.",
                 std_ends, bare_ends, surplus);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== smtp_data_transparency_engine_core.f =====
src/sdte_pkg.sv
src/sdte_if.sv
src/sdte_cfg.sv
src/sdte_step.sv
src/sdte_obuf.sv
src/smtp_data_transparency_engine_core.sv
src/sdte_checker.sv
tb/sdte_stream_compare.sv
tb/smtp_data_transparency_engine_core_test.sv
